/* rtl/coap_option_stream_parser_assert.svh */
// ----------------------------------------------------------------------------
// CoAP option stream parser assertion macros
// Shared concurrent assertion forms for the parser modules. Defining
// ASSERT_OFF turns every macro into an empty body.
// ----------------------------------------------------------------------------
`ifndef COAP_OPTION_STREAM_PARSER_ASSERT_SVH
`define COAP_OPTION_STREAM_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rs, expr, msg) \
  label: assert property (@(posedge ck) disable iff (!rs) (expr)) else $error(msg);
// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
    else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, ck, rs, expr, msg)
`define ASSERT_IMPL(label, ck, rs, ante, cons, msg)
`define ASSERT_NEXT(label, ck, rs, ante, cons, msg)
`endif
`endif

/* rtl/cosp_pkg.sv */
// ----------------------------------------------------------------------------
// CoAP option stream parser package
// Types, protocol constants and helper functions shared by the parser.
// ----------------------------------------------------------------------------
package cosp_pkg;

  // Width of the running byte position inside a message.
  localparam int unsigned POS_W = 16;

  // Depth of the result queue and its derived widths.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Protocol constants.
  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0]  NIB_EXT1       = 4'd13;
  localparam logic [3:0]  NIB_RSVD       = 4'd15;
  localparam logic [15:0] EXT1_OFS       = 16'd13;
  localparam logic [15:0] EXT2_OFS       = 16'd269;
  localparam logic [3:0]  TKL_MAX        = 4'd8;
  localparam logic [POS_W-1:0] HDR_LAST_POS = POS_W'(3);

  // Result kinds.
  localparam logic [1:0] RK_OPTION = 2'd0;
  localparam logic [1:0] RK_OK     = 2'd1;
  localparam logic [1:0] RK_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_TKL      = 3'd2;
  localparam logic [2:0] ERR_RESERVED = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  // Parse phases, one-hot.
  typedef enum logic [9:0] {
    PH_HEADER       = 10'b00_0000_0001,
    PH_TOKEN        = 10'b00_0000_0010,
    PH_OPTION       = 10'b00_0000_0100,
    PH_DELTA_EXT    = 10'b00_0000_1000,
    PH_DELTA_EXT_LO = 10'b00_0001_0000,
    PH_LEN_EXT      = 10'b00_0010_0000,
    PH_LEN_EXT_LO   = 10'b00_0100_0000,
    PH_VALUE        = 10'b00_1000_0000,
    PH_PAYLOAD      = 10'b01_0000_0000,
    PH_ERROR        = 10'b10_0000_0000
  } phase_t;

  // Complete parser state carried from one byte to the next.
  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic [3:0]       tok;
    logic [15:0]      acc;
    logic [3:0]       dnib;
    logic [3:0]       lnib;
    logic [7:0]       ext_hi;
    logic [15:0]      clen;
    logic [POS_W-1:0] cvs;
    logic [15:0]      left;
    logic [2:0]       err;
    logic [POS_W-1:0] pbeg;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  err;
    logic [15:0] num;
    logic [15:0] len;
    logic [15:0] voff;
    logic [15:0] poff;
    logic        last;
  } res_t;

  // State at reset and after every message end.
  function automatic state_t st_reset();
    state_t s;
    s        = '0;
    s.phase  = PH_HEADER;
    return s;
  endfunction

  // Low 16 bits of a position, zero-extended when positions are narrower.
  function automatic logic [15:0] pos_out(logic [POS_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

endpackage

/* rtl/cosp_step.sv */
// ----------------------------------------------------------------------------
// CoAP option stream parser byte step
// Decodes one message byte against the current parser state and produces
// the next state, an optional option result and an optional final result.
// ----------------------------------------------------------------------------
module cosp_step
  import cosp_pkg::*;
(
  input  state_t     st,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output state_t     st_nxt,
  output logic       opt_valid,
  output res_t       opt_res,
  output logic       fin_valid,
  output res_t       fin_res
);

  state_t           nx;
  logic             marker_now;
  logic             do_after_delta;
  logic             do_begin;
  logic [15:0]      len_new;
  logic [POS_W-1:0] pos_inc;
  logic [2:0]       fin_err;
  logic [POS_W-1:0] fin_poff;

  assign pos_inc = st.pos + POS_W'(1);

  always_comb begin
    nx             = st;
    marker_now     = 1'b0;
    do_after_delta = 1'b0;
    do_begin       = 1'b0;
    len_new        = '0;
    opt_valid      = 1'b0;
    opt_res        = '0;
    fin_valid      = 1'b0;
    fin_res        = '0;
    fin_err        = ERR_NONE;
    fin_poff       = '0;

    // Per-phase decode of the incoming byte.
    unique case (st.phase) inside
      PH_HEADER: begin
        if (st.pos == '0) begin
          nx.tok = data_byte[3:0];
        end
        if (st.pos >= HDR_LAST_POS) begin
          if (st.tok > TKL_MAX) begin
            nx.err   = ERR_TKL;
            nx.phase = PH_ERROR;
          end else if (st.tok == 4'd0) begin
            nx.phase = PH_OPTION;
          end else begin
            nx.phase = PH_TOKEN;
          end
        end
      end
      PH_TOKEN: begin
        nx.tok = st.tok - 4'd1;
        if (nx.tok == 4'd0) begin
          nx.phase = PH_OPTION;
        end
      end
      PH_OPTION: begin
        if (data_byte == PAYLOAD_MARKER) begin
          nx.pbeg    = pos_inc;
          nx.phase   = PH_PAYLOAD;
          marker_now = 1'b1;
        end else begin
          nx.dnib = data_byte[7:4];
          nx.lnib = data_byte[3:0];
          if (nx.dnib == NIB_RSVD || nx.lnib == NIB_RSVD) begin
            nx.err   = ERR_RESERVED;
            nx.phase = PH_ERROR;
          end else if (nx.dnib < NIB_EXT1) begin
            nx.acc         = st.acc + {12'd0, nx.dnib};
            do_after_delta = 1'b1;
          end else begin
            nx.phase = PH_DELTA_EXT;
          end
        end
      end
      PH_DELTA_EXT: begin
        if (st.dnib == NIB_EXT1) begin
          nx.acc         = st.acc + {8'd0, data_byte} + EXT1_OFS;
          do_after_delta = 1'b1;
        end else begin
          nx.ext_hi = data_byte;
          nx.phase  = PH_DELTA_EXT_LO;
        end
      end
      PH_DELTA_EXT_LO: begin
        nx.acc         = st.acc + {st.ext_hi, data_byte} + EXT2_OFS;
        do_after_delta = 1'b1;
      end
      PH_LEN_EXT: begin
        if (st.lnib == NIB_EXT1) begin
          len_new  = {8'd0, data_byte} + EXT1_OFS;
          do_begin = 1'b1;
        end else begin
          nx.ext_hi = data_byte;
          nx.phase  = PH_LEN_EXT_LO;
        end
      end
      PH_LEN_EXT_LO: begin
        len_new  = {st.ext_hi, data_byte} + EXT2_OFS;
        do_begin = 1'b1;
      end
      PH_VALUE: begin
        nx.left = st.left - 16'd1;
        if (nx.left == 16'd0) begin
          opt_valid    = 1'b1;
          opt_res.kind = RK_OPTION;
          opt_res.num  = st.acc;
          opt_res.len  = st.clen;
          opt_res.voff = pos_out(st.cvs);
          nx.phase     = PH_OPTION;
        end
      end
      PH_PAYLOAD, PH_ERROR: begin
      end
      default: begin
      end
    endcase

    // Delta is complete: take the length nibble or wait for its extension.
    if (do_after_delta) begin
      if (st.phase == PH_OPTION ? (nx.lnib < NIB_EXT1) : (st.lnib < NIB_EXT1)) begin
        len_new  = {12'd0, nx.lnib};
        do_begin = 1'b1;
      end else begin
        nx.phase = PH_LEN_EXT;
      end
    end

    // Length is known: a zero-length value completes the option at once.
    if (do_begin) begin
      nx.clen = len_new;
      nx.cvs  = pos_inc;
      if (len_new == 16'd0) begin
        opt_valid    = 1'b1;
        opt_res.kind = RK_OPTION;
        opt_res.num  = nx.acc;
        opt_res.len  = 16'd0;
        opt_res.voff = pos_out(pos_inc);
        nx.phase     = PH_OPTION;
      end else begin
        nx.left  = len_new;
        nx.phase = PH_VALUE;
      end
    end

    nx.pos = pos_inc;

    // Final result on the last byte of a message, then back to reset state.
    if (last_byte) begin
      case (nx.phase) inside
        PH_HEADER, PH_TOKEN: fin_err = ERR_SHORT;
        PH_OPTION:           fin_err = ERR_NONE;
        PH_PAYLOAD:          fin_poff = marker_now ? '0 : nx.pbeg;
        PH_ERROR:            fin_err = nx.err;
        default:             fin_err = ERR_TRUNC;
      endcase
      fin_valid    = 1'b1;
      fin_res.kind = (fin_err != ERR_NONE) ? RK_ERROR : RK_OK;
      fin_res.err  = fin_err;
      fin_res.poff = pos_out(fin_poff);
      fin_res.last = 1'b1;
      nx           = st_reset();
    end
    opt_res.last = opt_valid & ~last_byte;
  end

  assign st_nxt = nx;

endmodule

/* rtl/cosp_outq.sv */
// ----------------------------------------------------------------------------
// CoAP option stream parser result queue
// Small register queue that takes up to two results per cycle and hands
// them out one per transfer on the result channel.
// ----------------------------------------------------------------------------
`include "coap_option_stream_parser_assert.svh"

module cosp_outq
  import cosp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push0,
  input  res_t       push1,
  output logic       space_ok,
  input  logic       pop_ready,
  output logic       pop_valid,
  output res_t       pop_res
);

  res_t                mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_r;
  logic [OQ_PTR_W-1:0] wr_nxt;
  logic [OQ_PTR_W-1:0] rd_r;
  logic [OQ_PTR_W-1:0] rd_nxt;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic [OQ_CNT_W-1:0] cnt_nxt;
  logic [OQ_PTR_W-1:0] wr_plus1;
  logic                pop;

  assign pop       = pop_valid & pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_res   = mem_r[rd_r];
  assign space_ok  = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign wr_plus1  = wr_r + OQ_PTR_W'(1);

  // Pointer and occupancy update.
  always_comb begin
    wr_nxt  = wr_r + OQ_PTR_W'(push_n);
    rd_nxt  = pop ? rd_r + OQ_PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_plus1] <= push1;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= OQ_CNT_W'(OQ_DEPTH), "queue overfilled")
  `ASSERT_IMPL(a_push_room, clk, rst_n, push_n != 2'd0, space_ok, "push without room")
  `ASSERT_NEXT(a_cnt_two, clk, rst_n, push_n == 2'd2 && !pop, cnt_r == $past(cnt_r) + OQ_CNT_W'(2), "double push not counted")

endmodule

/* rtl/coap_option_stream_parser.sv */
// A result is queued on its byte's transfer and is on the out_ ports once all
// results queued ahead of it have left. Throughput: one byte per cycle while
// in_ready is high. A byte that completes an option and ends the message gives
// two results, so in_ready is high while the 4-entry queue has room for two.
// Reset (rst_n low, synchronous) returns the parser to the header phase and
// empties the result queue; the parser also returns there after every last byte.
// ----------------------------------------------------------------------------
// CoAP option stream parser
// Parses a CoAP message one byte per transfer: fixed header, token, options
// with extended delta and length, payload marker; reports each option and
// the end of the message.
// ----------------------------------------------------------------------------
`include "coap_option_stream_parser_assert.svh"

module coap_option_stream_parser
  import cosp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_option_number,
  output logic [15:0] out_option_length,
  output logic [15:0] out_value_offset,
  output logic [15:0] out_payload_offset,
  output logic        out_last_of_run
);

  state_t     state_r;
  state_t     state_nxt;
  logic       opt_valid;
  res_t       opt_res;
  logic       fin_valid;
  res_t       fin_res;
  logic       in_xfer;
  logic [1:0] push_n;
  res_t       push0;
  res_t       q_res;

  assign in_xfer = in_valid & in_ready;

  // Byte decode.
  cosp_step u_step (
    .st        (state_r),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .st_nxt    (state_nxt),
    .opt_valid (opt_valid),
    .opt_res   (opt_res),
    .fin_valid (fin_valid),
    .fin_res   (fin_res)
  );

  // Parser state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= st_reset();
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // The option result goes ahead of the final result.
  assign push_n = in_xfer ? (2'(opt_valid) + 2'(fin_valid)) : 2'd0;
  assign push0  = opt_valid ? opt_res : fin_res;

  cosp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (push0),
    .push1     (fin_res),
    .space_ok  (in_ready),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_res   (q_res)
  );

  assign out_result_kind    = q_res.kind;
  assign out_error_code     = q_res.err;
  assign out_option_number  = q_res.num;
  assign out_option_length  = q_res.len;
  assign out_value_offset   = q_res.voff;
  assign out_payload_offset = q_res.poff;
  assign out_last_of_run    = q_res.last;

  `ASSERT_NEXT(a_last_resets, clk, rst_n, in_xfer && in_last_byte, state_r.phase == PH_HEADER && state_r.pos == '0, "no return to header after last byte")
  `ASSERT_IMPL(a_err_phase, clk, rst_n, state_r.err != ERR_NONE, state_r.phase == PH_ERROR, "error latched outside error phase")
  `ASSERT_IMPL(a_token_left, clk, rst_n, state_r.phase == PH_TOKEN, state_r.tok != 4'd0, "token phase with nothing to skip")

endmodule
